FILE: hdl/hprc_pkg.sv
package hprc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_HOME_VALUE     = 3'd0,
    REG_GAIN_P         = 3'd1,
    REG_GAIN_I         = 3'd2,
    REG_GAIN_D         = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_RATE_CAP       = 3'd5
  } cfg_reg_t;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned ERR_W   = 12;
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned INTEG_W = 16;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned OUT_W   = 12;

  localparam logic [11:0] HOME_VALUE_RST     = 12'd2580;
  localparam logic [7:0]  GAIN_P_RST         = 8'd5;
  localparam logic [7:0]  GAIN_I_RST         = 8'd0;
  localparam logic [7:0]  GAIN_D_RST         = 8'd0;
  localparam logic [15:0] INTEGRAL_LIMIT_RST = 16'd100;
  localparam logic [11:0] RATE_CAP_RST       = 12'd2000;

  // m_tdata layout
  localparam int unsigned OUT_CCW_BIT  = 0;
  localparam int unsigned OUT_RATE_LSB = 1;
  localparam int unsigned OUT_RATE_MSB = 12;
  localparam int unsigned OUT_HOME_BIT = 13;

  typedef struct packed {
    logic [11:0] home_value;
    logic [7:0]  gain_p;
    logic [7:0]  gain_i;
    logic [7:0]  gain_d;
    logic [15:0] integral_limit;
    logic [11:0] rate_cap;
  } cfg_t;

  // Terms handed from the error stage to the rate stage
  typedef struct packed {
    logic              at_home;
    logic              turn_ccw;
    logic [ERR_W-1:0]  err;
    logic [INTEG_W-1:0] integ;
    logic [RATE_W-1:0] diff;
  } mid_t;

  typedef struct packed {
    logic             at_home;
    logic [OUT_W-1:0] step_rate;
    logic             turn_ccw;
  } res_t;

endpackage

FILE: hdl/hprc_rate.sv
module hprc_rate (
  input  hprc_pkg::cfg_t cfg,
  input  hprc_pkg::mid_t mid,
  output hprc_pkg::res_t res
);

  logic [19:0] prod_p;
  logic [23:0] prod_i;
  logic [23:0] prod_d;
  logic [15:0] rate_sum;
  logic [15:0] rate_min1;
  logic [15:0] cap_ext;
  logic [11:0] rate_sat;

  assign prod_p = mid.err * cfg.gain_p;
  assign prod_i = mid.integ * cfg.gain_i;
  assign prod_d = mid.diff * cfg.gain_d;

  // sum wraps at 16 bits
  assign rate_sum = prod_p[15:0] + prod_i[15:0] + prod_d[15:0];

  assign rate_min1 = (rate_sum == 16'd0) ? 16'd1 : rate_sum;
  assign cap_ext   = {4'd0, cfg.rate_cap};
  assign rate_sat  = (rate_min1 > cap_ext) ? cfg.rate_cap : rate_min1[11:0];

  always_comb begin
    res.at_home = mid.at_home;
    if (mid.at_home) begin
      res.turn_ccw  = 1'b0;
      res.step_rate = '0;
    end else begin
      res.turn_ccw  = mid.turn_ccw;
      res.step_rate = rate_sat;
    end
  end

endmodule

FILE: hdl/homing_pid_rate_controller.sv
// Homing PID rate controller. Each input word carries one 12-bit position
// sample and a restart flag; each output word carries the turn direction,
// the commanded step rate and an at-home flag. A sample equal to home_value
// gives at_home=1, rate 0 and clears the previous error and the integral.
// Otherwise the error is |position - home_value| (below home turns CCW), the
// integral is clamped at integral_limit, and the rate is
// gain_p*err + gain_i*integ + gain_d*(err - prev_err), wrapped to 16 bits,
// forced to at least 1 and saturated at rate_cap. Throughput is one word per
// clock while the output is not stalled; a result passes from the input
// register through the error stage into the middle register and through the
// rate stage into the output register. The error/integral state closes its
// loop within the error stage (12-bit subtract and a 17-bit add with clamp),
// which is what lets samples follow back to back. Configuration writes are
// always taken (cfg_ready=1) and belong to idle periods; indexes 6 and 7 are
// ignored.
module homing_pid_rate_controller (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] position, [12] restart, [15:13] zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] turn_ccw, [12:1] step_rate, [13] at_home, [15:14] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  hprc_pkg::cfg_t cfg;

  // input register
  logic        in_valid;
  logic [11:0] in_pos;
  logic        in_restart;

  // controller state
  logic [11:0] prev_err;
  logic [15:0] err_int;

  // error stage -> rate stage
  logic           mid_valid;
  hprc_pkg::mid_t mid;
  hprc_pkg::mid_t mid_next;

  // output register
  logic           out_valid;
  hprc_pkg::res_t out_res;
  hprc_pkg::res_t res_next;

  logic out_ready;
  logic mid_ready;
  logic in_take;
  logic mid_take;
  logic out_take;

  // error stage signals
  logic        pos_below;
  logic [11:0] err;
  logic [11:0] prev_eff;
  logic [15:0] int_eff;
  logic [16:0] int_sum;
  logic [15:0] integ;

  // Per-stage ready: a stage takes a word when empty or draining.
  assign out_ready = !out_valid || m_tready;
  assign mid_ready = !mid_valid || out_ready;
  assign s_tready  = !in_valid || mid_ready;
  assign in_take   = s_tvalid && s_tready;
  assign mid_take  = in_valid && mid_ready;
  assign out_take  = mid_valid && out_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.home_value     <= hprc_pkg::HOME_VALUE_RST;
      cfg.gain_p         <= hprc_pkg::GAIN_P_RST;
      cfg.gain_i         <= hprc_pkg::GAIN_I_RST;
      cfg.gain_d         <= hprc_pkg::GAIN_D_RST;
      cfg.integral_limit <= hprc_pkg::INTEGRAL_LIMIT_RST;
      cfg.rate_cap       <= hprc_pkg::RATE_CAP_RST;
    end else if (cfg_valid) begin
      case (hprc_pkg::cfg_reg_t'(cfg_index))
        hprc_pkg::REG_HOME_VALUE:     cfg.home_value     <= cfg_data[11:0];
        hprc_pkg::REG_GAIN_P:         cfg.gain_p         <= cfg_data[7:0];
        hprc_pkg::REG_GAIN_I:         cfg.gain_i         <= cfg_data[7:0];
        hprc_pkg::REG_GAIN_D:         cfg.gain_d         <= cfg_data[7:0];
        hprc_pkg::REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data;
        hprc_pkg::REG_RATE_CAP:       cfg.rate_cap       <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  // Error stage: direction, |error|, difference and clamped integral.
  // Restart zeroes the state seen by this sample.
  assign pos_below = in_pos < cfg.home_value;
  assign err       = pos_below ? (cfg.home_value - in_pos) : (in_pos - cfg.home_value);
  assign prev_eff  = in_restart ? 12'd0 : prev_err;
  assign int_eff   = in_restart ? 16'd0 : err_int;
  assign int_sum   = {1'b0, int_eff} + {5'd0, err};
  assign integ     = (int_sum > {1'b0, cfg.integral_limit}) ? cfg.integral_limit
                                                            : int_sum[15:0];

  always_comb begin
    mid_next.at_home  = (in_pos == cfg.home_value);
    mid_next.turn_ccw = pos_below;
    mid_next.err      = err;
    mid_next.integ    = integ;
    mid_next.diff     = {4'd0, err} - {4'd0, prev_eff};
  end

  hprc_rate u_rate (
    .cfg (cfg),
    .mid (mid),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
      prev_err  <= '0;
      err_int   <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (mid_ready) begin
        mid_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= mid_valid;
      end
      // state advances as a sample leaves the error stage
      if (mid_take) begin
        if (mid_next.at_home) begin
          prev_err <= '0;
          err_int  <= '0;
        end else begin
          prev_err <= err;
          err_int  <= integ;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_pos     <= s_tdata[11:0];
      in_restart <= s_tdata[12];
    end
    if (mid_take) begin
      mid <= mid_next;
    end
    if (out_take) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.at_home, out_res.step_rate, out_res.turn_ccw};

endmodule

FILE: hdl/hprc_checker.sv
module hprc_props (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  logic out_home;
  logic out_ccw;
  logic [11:0] out_rate;

  assign out_home = m_tdata[hprc_pkg::OUT_HOME_BIT];
  assign out_ccw  = m_tdata[hprc_pkg::OUT_CCW_BIT];
  assign out_rate = m_tdata[hprc_pkg::OUT_RATE_MSB:hprc_pkg::OUT_RATE_LSB];

  // home result carries no motion
  a_home_stops: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_home) |-> (out_rate == 12'd0 && !out_ccw))
    else $error("at_home result with nonzero rate or CCW");

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output word changed while stalled");

  // input side only backs up when the output is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // register writes are never held off
  a_cfg_taken: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write held off");

endmodule

bind homing_pid_rate_controller hprc_props u_hprc_props (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
